FILE: src/gbn_pkg.sv
// Shared types and constants of the greedy box suppression filter.
package gbn_pkg;

   localparam int COORD_W = 16;
   localparam int SIDE_W  = 17;
   localparam int AREA_W  = 33;
   localparam int UNION_W = 34;
   localparam int THR_W   = 16;
   localparam int KEEP_W  = 9;
   localparam int INDEX_W = 13;
   localparam int RSP_W   = 24;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_MAX_KEEP  = 1'b1;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd45875;
   localparam logic [KEEP_W-1:0] MAX_KEEP_RESET  = 9'd256;

   typedef struct packed {
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y2;
   } box_type;

   typedef struct packed {
      logic valid;
      logic is_area;
   } op_type;

   typedef struct packed {
      logic valid;
      logic is_area;
      logic hit;
   } res_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage

FILE: src/greedy_box_nms_filter.sv
// Top level of the greedy box suppression filter: sequencer, registers and result stage.
//
// Boxes of a set arrive on the req_ channel in descending score order, one
// transaction each; req_tuser high opens a new set. Each box gives exactly one
// transaction on the rsp_ channel with its kept flag, index in the set, the
// kept count after it and a list-full flag.
// The csr_ port writes the IoU threshold (index 0) and the keep limit
// (index 1); write them only while no box is in flight.
// A box is tested against the kept boxes one per cycle through a five-stage
// overlap unit fed from the kept-box memory, after one pass of the same unit
// that measures the box's own area; when the list is already full it skips
// the scan and goes straight to its result. The next box is taken once the
// result is in the output register. The first suppressing match ends the
// scan early. Reset empties the set, restores the register defaults and
// clears the output register; the memory needs no clearing. While the
// receiver stalls, one result waits in the output register and one more
// box may be accepted and worked on; it then waits to finish until the
// register empties.
module greedy_box_nms_filter #(
   parameter int MAX_KEEP        = 256,
   parameter int MAX_BOXES       = 8192,
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // box_x1, box_y1, box_x2, box_y2
   input  logic        req_tuser,   // start_of_set
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // kept, box_index, kept_rank, list_full
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import gbn_pkg::*;

   localparam int AW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CW    = $clog2(MAX_KEEP + 1);
   localparam int LW    = (CW > KEEP_W) ? CW : KEEP_W;
   localparam int IW    = $clog2(MAX_BOXES);
   localparam int OW    = (IW > INDEX_W) ? IW : INDEX_W;
   localparam int MEM_W = 4 * COORD_W + AREA_W;
   localparam logic [LW-1:0] KEEP_CAP  = LW'(MAX_KEEP);
   localparam logic [IW-1:0] INDEX_TOP = IW'(MAX_BOXES - 1);

   state_type         state_ff, state_in;
   logic [THR_W-1:0]  thr_ff;
   logic [KEEP_W-1:0] max_keep_ff;
   box_type           box_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     index_ff, index_in;
   logic [IW-1:0]     cur_idx_ff, cur_idx_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic [CW-1:0]     ret_ff, ret_in;
   logic              keep_ff, keep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [LW-1:0]     limit;
   logic [LW-1:0]     max_keep_l;
   logic [CW-1:0]     eff_count;
   logic [IW-1:0]     idx_base;
   logic [CW-1:0]     rd_ptr;
   logic [CW-1:0]     new_count;
   logic [LW-1:0]     new_count_l;
   logic [OW-1:0]     idx_out;
   logic              list_full;
   logic              flush;
   logic              out_free;
   logic              mem_we;
   op_type            op;
   res_type           res;
   logic [AREA_W-1:0] area;
   logic [MEM_W-1:0]  mem_rdata;
   box_type           mem_box;
   logic [AREA_W-1:0] mem_area;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign max_keep_l = LW'(max_keep_ff);
   assign limit      = (max_keep_l < KEEP_CAP) ? max_keep_l : KEEP_CAP;
   assign eff_count  = req_tuser ? '0 : count_ff;
   assign idx_base   = req_tuser ? '0 : index_ff;
   assign rd_ptr     = iss_ff - 1'b1;
   assign new_count  = count_ff + CW'(keep_ff);
   assign new_count_l = LW'(new_count);
   assign idx_out    = OW'(cur_idx_ff);
   assign list_full  = (new_count_l >= limit);
   assign mem_we     = (state_ff == S_DONE) && out_free && keep_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      cur_idx_in   = cur_idx_ff;
      iss_in       = iss_ff;
      ret_in       = ret_ff;
      keep_in      = keep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      flush        = 1'b0;
      op           = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in   = eff_count;
               cur_idx_in = idx_base;
               index_in   = (idx_base < INDEX_TOP) ? idx_base + 1'b1 : idx_base;
               iss_in     = '0;
               ret_in     = '0;
               keep_in    = 1'b0;
               state_in   = (LW'(eff_count) >= limit) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (iss_ff <= count_ff) begin
               op.valid   = 1'b1;
               op.is_area = (iss_ff == '0);
               iss_in     = iss_ff + 1'b1;
            end
            if (res.valid) begin
               ret_in = ret_ff + 1'b1;
               if (!res.is_area && res.hit) begin
                  keep_in  = 1'b0;
                  flush    = 1'b1;
                  state_in = S_DONE;
               end else if (ret_ff == count_ff) begin
                  keep_in  = 1'b1;
                  flush    = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {list_full, new_count_l[KEEP_W-1:0],
                               idx_out[INDEX_W-1:0], keep_ff};
               count_in     = new_count;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         max_keep_ff  <= MAX_KEEP_RESET;
         count_ff     <= '0;
         index_ff     <= '0;
         iss_ff       <= '0;
         ret_ff       <= '0;
         keep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         iss_ff       <= iss_in;
         ret_ff       <= ret_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: thr_ff      <= csr_wdata;
               CSR_MAX_KEEP:  max_keep_ff <= csr_wdata[KEEP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff  <= cur_idx_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         box_ff.x1 <= req_tdata[15:0];
         box_ff.y1 <= req_tdata[31:16];
         box_ff.x2 <= req_tdata[47:32];
         box_ff.y2 <= req_tdata[63:48];
      end
   end

   gbn_kept_mem #(
      .DEPTH (MAX_KEEP),
      .AW    (AW),
      .WIDTH (MEM_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (count_ff[AW-1:0]),
      .wdata ({box_ff, area}),
      .re    (op.valid),
      .raddr (rd_ptr[AW-1:0]),
      .rdata (mem_rdata)
   );

   assign mem_box  = mem_rdata[MEM_W-1:AREA_W];
   assign mem_area = mem_rdata[AREA_W-1:0];

   gbn_iou_unit #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_iou (
      .clock     (clock),
      .reset     (reset),
      .flush     (flush),
      .op        (op),
      .cur_box   (box_ff),
      .mem_box   (mem_box),
      .mem_area  (mem_area),
      .threshold (thr_ff),
      .res       (res),
      .area      (area)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/gbn_kept_mem.sv
// Memory of kept boxes and their areas, one write port and one registered read port.
module gbn_kept_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int WIDTH = 97
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/gbn_iou_unit.sv
// Pipelined overlap unit: one intersection-over-union threshold test per cycle.
module gbn_iou_unit #(
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  flush,
   input  gbn_pkg::op_type       op,
   input  gbn_pkg::box_type      cur_box,
   input  gbn_pkg::box_type      mem_box,
   input  logic [32:0]           mem_area,
   input  logic [15:0]           threshold,
   output gbn_pkg::res_type      res,
   output logic [32:0]           area
);
   import gbn_pkg::*;

   localparam logic signed [17:0] ONE = 18'sd1 <<< COORD_FRAC_BITS;

   function automatic logic [SIDE_W-1:0] side_len(input logic [COORD_W-1:0] lo,
                                                  input logic [COORD_W-1:0] hi);
      logic signed [17:0] s;
      s = $signed({2'b00, hi}) - $signed({2'b00, lo}) + ONE;
      return (s < 0) ? '0 : s[SIDE_W-1:0];
   endfunction

   op_type               op0_ff, op1_ff, op2_ff, op3_ff, op4_ff;
   logic [SIDE_W-1:0]    iw1_ff, ih1_ff;
   logic [AREA_W-1:0]    karea1_ff, karea2_ff;
   logic [AREA_W-1:0]    prod2_ff, prod3_ff;
   logic [UNION_W-1:0]   uni3_ff;
   logic                 hit4_ff;
   logic [AREA_W-1:0]    area_ff;

   box_type              opnd;
   logic [COORD_W-1:0]   lo_x, lo_y, hi_x, hi_y;
   logic [SIDE_W-1:0]    iw_in, ih_in;
   logic [2*SIDE_W-1:0]  prod_full;
   logic [UNION_W-1:0]   uni_in;
   logic [48:0]          lhs;
   logic [49:0]          rhs;
   logic                 hit_in;

   always_comb begin
      opnd = op0_ff.is_area ? cur_box : mem_box;
      lo_x = (cur_box.x1 > opnd.x1) ? cur_box.x1 : opnd.x1;
      lo_y = (cur_box.y1 > opnd.y1) ? cur_box.y1 : opnd.y1;
      hi_x = (cur_box.x2 < opnd.x2) ? cur_box.x2 : opnd.x2;
      hi_y = (cur_box.y2 < opnd.y2) ? cur_box.y2 : opnd.y2;
      iw_in = side_len(lo_x, hi_x);
      ih_in = side_len(lo_y, hi_y);
      prod_full = iw1_ff * ih1_ff;
      uni_in = {1'b0, karea2_ff} + {1'b0, area_ff} - {1'b0, prod2_ff};
      lhs = {prod3_ff, 16'h0000};
      rhs = threshold * uni3_ff;
      hit_in = {1'b0, lhs} > rhs;
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         op0_ff <= '0;
         op1_ff <= '0;
         op2_ff <= '0;
         op3_ff <= '0;
         op4_ff <= '0;
      end else begin
         op0_ff <= op;
         op1_ff <= op0_ff;
         op2_ff <= op1_ff;
         op3_ff <= op2_ff;
         op4_ff <= op3_ff;
      end
   end

   always_ff @(posedge clock) begin
      iw1_ff    <= iw_in;
      ih1_ff    <= ih_in;
      karea1_ff <= mem_area;
      karea2_ff <= karea1_ff;
      prod2_ff  <= prod_full[AREA_W-1:0];
      prod3_ff  <= prod2_ff;
      uni3_ff   <= uni_in;
      hit4_ff   <= hit_in;
      if (op1_ff.valid && op1_ff.is_area) begin
         area_ff <= prod_full[AREA_W-1:0];
      end
   end

   always_comb begin
      res.valid   = op4_ff.valid;
      res.is_area = op4_ff.is_area;
      res.hit     = hit4_ff;
   end

   assign area = area_ff;

endmodule

FILE: src/gbn_checker.sv
// Port-level checker of the greedy box suppression filter and its bind.
module gbn_checker #(
   parameter int MAX_KEEP = 256
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_we,
   input logic [0:0]  csr_index,
   input logic [15:0] csr_wdata
);

   // A stalled result must hold its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Each accepted box keeps the block busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on two consecutive cycles");

   // A kept box always leaves a nonzero kept count.
   a_kept_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (MAX_KEEP >= 512) || !rsp_tdata[0] || (rsp_tdata[22:14] != 9'd0))
      else $error("kept box reported with zero rank");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind greedy_box_nms_filter gbn_checker #(.MAX_KEEP(MAX_KEEP)) u_gbn_checker (.*);

FILE: bench/greedy_box_nms_filter_tb.sv
// Self-checking testbench of the greedy box suppression filter with its own IoU predictor.
module greedy_box_nms_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbn_pkg::*;

   localparam int MAX_KEEP_N  = 256;
   localparam int MAX_BOXES_N = 8192;
   localparam int FRAC_BITS   = 4;
   localparam int ONE_PIXEL   = 1 << FRAC_BITS;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic               start;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y2;
      bit                 drain;
   } box_req_type;

   typedef struct {
      logic               kept;
      logic [INDEX_W-1:0] box_index;
      logic [KEEP_W-1:0]  kept_rank;
      logic               list_full;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   box_req_type pending_boxes[$];
   verdict_type box_verdicts[$];
   box_req_type next_box;
   bit          req_taken;
   int          send_idle_pct;
   int          stall_pct;
   int          mismatches;
   int          idle_cycles;
   int          boxes_seen;
   int          kept_seen;
   int          suppressed_seen;
   int          dropped_seen;
   int          saturated_seen;
   int          config_phases;

   // Predictor state: kept list of the current set and the register copies.
   logic [COORD_W-1:0] keep_x1[MAX_KEEP_N];
   logic [COORD_W-1:0] keep_y1[MAX_KEEP_N];
   logic [COORD_W-1:0] keep_x2[MAX_KEEP_N];
   logic [COORD_W-1:0] keep_y2[MAX_KEEP_N];
   longint             keep_area[MAX_KEEP_N];
   int                 kept_total;
   int                 set_position;
   longint             thr_cfg = 45875;
   int                 keep_cfg = 256;

   greedy_box_nms_filter #(
      .MAX_KEEP        (MAX_KEEP_N),
      .MAX_BOXES       (MAX_BOXES_N),
      .COORD_FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint span(longint lo, longint hi);
      longint s;
      s = hi - lo + ONE_PIXEL;
      return (s > 0) ? s : 0;
   endfunction

   function automatic longint max2(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic longint min2(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic verdict_type judge_box(logic start, logic [COORD_W-1:0] x1,
                                             logic [COORD_W-1:0] y1, logic [COORD_W-1:0] x2,
                                             logic [COORD_W-1:0] y2);
      verdict_type v;
      longint      area;
      longint      inter;
      longint      uni;
      int          limit;
      area = span(x1, x2) * span(y1, y2);
      if (start) begin
         kept_total = 0;
         set_position = 0;
      end
      v.box_index = set_position[INDEX_W-1:0];
      if (set_position < MAX_BOXES_N - 1) begin
         set_position++;
      end
      limit = (keep_cfg < MAX_KEEP_N) ? keep_cfg : MAX_KEEP_N;
      v.kept = 1'b0;
      if (kept_total < limit) begin
         v.kept = 1'b1;
         for (int k = 0; k < kept_total; k++) begin
            inter = span(max2(x1, keep_x1[k]), min2(x2, keep_x2[k])) *
                    span(max2(y1, keep_y1[k]), min2(y2, keep_y2[k]));
            uni = keep_area[k] + area - inter;
            if (inter * 65536 > thr_cfg * uni) begin
               v.kept = 1'b0;
               break;
            end
         end
         if (v.kept) begin
            keep_x1[kept_total] = x1;
            keep_y1[kept_total] = y1;
            keep_x2[kept_total] = x2;
            keep_y2[kept_total] = y2;
            keep_area[kept_total] = area;
            kept_total++;
         end
      end
      v.kept_rank = kept_total[KEEP_W-1:0];
      v.list_full = (kept_total >= limit);
      return v;
   endfunction

   // Result checking, box prediction and the watchdog share the rising edge.
   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      bit          moved;
      moved = csr_we;
      if (!reset && rsp_tvalid && rsp_tready) begin
         moved = 1'b1;
         got.kept      = rsp_tdata[0];
         got.box_index = rsp_tdata[13:1];
         got.kept_rank = rsp_tdata[22:14];
         got.list_full = rsp_tdata[23];
         if (box_verdicts.size() == 0) begin
            $error("result transaction with no box outstanding: data %h", rsp_tdata);
            mismatches++;
         end else begin
            want = box_verdicts.pop_front();
            if (got.kept !== want.kept) begin
               $error("kept: expected %0d, actual %0d", want.kept, got.kept);
               mismatches++;
            end
            if (got.box_index !== want.box_index) begin
               $error("box_index: expected %0d, actual %0d", want.box_index, got.box_index);
               mismatches++;
            end
            if (got.kept_rank !== want.kept_rank) begin
               $error("kept_rank: expected %0d, actual %0d", want.kept_rank, got.kept_rank);
               mismatches++;
            end
            if (got.list_full !== want.list_full) begin
               $error("list_full: expected %0d, actual %0d", want.list_full, got.list_full);
               mismatches++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         moved = 1'b1;
         req_taken = 1'b1;
         want = judge_box(req_tuser, req_tdata[15:0], req_tdata[31:16],
                          req_tdata[47:32], req_tdata[63:48]);
         box_verdicts.push_back(want);
         boxes_seen++;
         if (want.kept) begin
            kept_seen++;
         end else if (want.list_full) begin
            dropped_seen++;
         end else begin
            suppressed_seen++;
         end
         if (want.box_index == MAX_BOXES_N - 1) begin
            saturated_seen++;
         end
      end
      if (reset || moved) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      logic go;
      go = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle_pct &&
             !(pending_boxes[0].drain && box_verdicts.size() != 0)) begin
            next_box = pending_boxes.pop_front();
            go = 1'b1;
            req_tdata <= {next_box.y2, next_box.x2, next_box.y1, next_box.x1};
            req_tuser <= next_box.start;
         end
         req_tvalid <= go;
      end
      req_taken = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [COORD_W-1:0] clip16(int v);
      if (v < 0) begin
         return '0;
      end
      if (v > 65535) begin
         return 16'hFFFF;
      end
      return v[15:0];
   endfunction

   task automatic enqueue_box(logic start, int x1, int y1, int x2, int y2, bit drain = 0);
      box_req_type b;
      b.start = start;
      b.x1 = clip16(x1);
      b.y1 = clip16(y1);
      b.x2 = clip16(x2);
      b.y2 = clip16(y2);
      b.drain = drain;
      pending_boxes.push_back(b);
   endtask

   task automatic settle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_boxes.size() != 0 || req_tvalid || box_verdicts.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_THRESHOLD) begin
         thr_cfg = value;
      end else begin
         keep_cfg = value[KEEP_W-1:0];
      end
   endtask

   task automatic configure(int thr, int keep, int send_pct, int rsp_pct);
      settle();
      write_reg(CSR_THRESHOLD, thr[15:0]);
      write_reg(CSR_MAX_KEEP, keep[15:0]);
      send_idle_pct = send_pct;
      stall_pct = rsp_pct;
      config_phases++;
   endtask

   task automatic random_sets(int boxes);
      int made;
      int len;
      int n_anchor;
      int a;
      int jw;
      int jh;
      int mode;
      int x1;
      int y1;
      int x2;
      int y2;
      int ax[4];
      int ay[4];
      int aw[4];
      int ah[4];
      logic start;
      made = 0;
      while (made < boxes) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
         n_anchor = $urandom_range(4, 1);
         for (int i = 0; i < 4; i++) begin
            ax[i] = $urandom_range(60000);
            ay[i] = $urandom_range(60000);
            aw[i] = $urandom_range(2000, 16);
            ah[i] = $urandom_range(2000, 16);
         end
         for (int i = 0; i < len && made < boxes; i++) begin
            start = (i == 0) ? ($urandom_range(15) != 0) : ($urandom_range(49) == 0);
            mode = $urandom_range(99);
            if (mode < 55) begin
               a = $urandom_range(n_anchor - 1);
               jw = aw[a] / 4 + 1;
               jh = ah[a] / 4 + 1;
               x1 = ax[a] + int'($urandom_range(2 * jw)) - jw;
               y1 = ay[a] + int'($urandom_range(2 * jh)) - jh;
               x2 = x1 + aw[a] + int'($urandom_range(2 * jw)) - jw;
               y2 = y1 + ah[a] + int'($urandom_range(2 * jh)) - jh;
            end else if (mode < 75) begin
               x1 = $urandom_range(65535);
               y1 = $urandom_range(65535);
               x2 = x1 + int'($urandom_range(800));
               y2 = y1 + int'($urandom_range(800));
            end else if (mode < 88) begin
               x1 = $urandom_range(65535);
               y1 = $urandom_range(65535);
               x2 = $urandom_range(65535);
               y2 = $urandom_range(65535);
            end else if (mode < 94) begin
               x1 = $urandom_range(65535, 200);
               y1 = $urandom_range(65535);
               x2 = x1 - int'($urandom_range(199, 16));
               y2 = y1 + int'($urandom_range(400));
            end else begin
               x1 = $urandom_range(1) ? 65535 : 0;
               y1 = $urandom_range(1) ? 65535 : 0;
               x2 = $urandom_range(1) ? 65535 : 0;
               y2 = $urandom_range(1) ? 65535 : 0;
            end
            enqueue_box(start, x1, y1, x2, y2, $urandom_range(199) == 0);
            made++;
         end
      end
   endtask

   initial begin
      int thr_pick;
      int keep_pick;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset register values: duplicates, extremes, full frame and inverted boxes.
      enqueue_box(1, 0, 0, 0, 0);
      enqueue_box(0, 0, 0, 0, 0);
      enqueue_box(0, 65535, 65535, 65535, 65535);
      enqueue_box(0, 0, 0, 65535, 65535);
      enqueue_box(0, 0, 0, 65535, 65535);
      enqueue_box(0, 100, 100, 50, 50);
      enqueue_box(0, 200, 300, 10, 20, 1);
      enqueue_box(1, 160, 160, 319, 319);
      enqueue_box(0, 176, 160, 335, 319);
      enqueue_box(0, 240, 160, 399, 319);
      enqueue_box(0, 65535, 0, 0, 65535);
      enqueue_box(0, 0, 65535, 65535, 0);

      configure(0, 1, 0, 0);
      enqueue_box(1, 0, 0, 15, 15);
      enqueue_box(0, 500, 500, 515, 515);

      configure(0, 2, 0, 0);
      enqueue_box(1, 0, 0, 15, 15);
      enqueue_box(0, 15, 15, 30, 30);
      enqueue_box(0, 100, 100, 115, 115);

      configure(65535, 256, 0, 0);
      enqueue_box(1, 1000, 1000, 1999, 1999);
      enqueue_box(0, 1000, 1000, 1999, 1999);

      // IoU of exactly one half sits on the threshold and must survive.
      configure(32768, 3, 0, 0);
      enqueue_box(1, 0, 0, 16, 15);
      enqueue_box(0, 0, 0, 0, 15);
      enqueue_box(0, 0, 0, 1, 15);

      // A set that fills the whole kept list, then boxes dropped on a full list.
      configure(45875, 256, 0, 0);
      for (int i = 0; i < 260; i++) begin
         enqueue_box(i == 0, (i % 16) * 4000, ((i / 16) % 16) * 4000,
                     (i % 16) * 4000 + 3000, ((i / 16) % 16) * 4000 + 3000, i == 256);
      end

      configure(45875, 256, 0, 0);
      random_sets(195);
      thr_pick = $urandom_range(65535);
      keep_pick = $urandom_range(256, 1);
      configure(thr_pick, keep_pick, 81, 0);
      random_sets(195);
      configure(0, 8, 0, 81);
      random_sets(195);
      configure(65535, 256, 34, 34);
      random_sets(195);
      keep_pick = $urandom_range(40, 1);
      configure(32768, keep_pick, 0, 0);
      random_sets(195);

      settle();
      repeat (300) @(posedge clock);
      $display("Covered %0d boxes over %0d register settings: %0d kept, %0d suppressed,",
               boxes_seen, config_phases + 1, kept_seen, suppressed_seen);
      $display("%0d dropped on a full list and %0d with a saturated index.",
               dropped_seen, saturated_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
